/* hdl/mridu_pkg.sv */
// ----------------------------------------------------------------------------
// mridu_pkg
// Shared widths and pipeline types for the mixed-radix index digit unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mridu_pkg;

    localparam int IDX_W   = 48;
    localparam int RADIX_W = 12;
    localparam int POS_W   = 3;
    localparam int NREGS   = 4;
    localparam int REG_W   = 2;

    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // One slot of the digit extraction pipeline
    typedef struct packed {
        logic               valid;
        logic               cmd;
        logic               err;
        logic [IDX_W-1:0]   idx;
        logic [RADIX_W-1:0] dig;
        logic [IDX_W-1:0]   s;
        logic [RADIX_W-1:0] r;
        logic [IDX_W-1:0]   rem;
        logic [RADIX_W-1:0] m;
    } t_slot;

endpackage

`default_nettype wire

/* hdl/mixed_radix_index_digit_unit.sv */
// ----------------------------------------------------------------------------
// mixed_radix_index_digit_unit
// Decodes or replaces one digit of a flat index read as a mixed-radix number.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle while no stall or stride recompute holds
// the input. The flat index is divided by the stride of the chosen
// position in a restoring divider of 48 stages, one quotient bit per stage;
// each stage also folds that quotient bit into a running value of
// quotient mod radix, so the old digit is ready at the end of the divider.
// Three more stages form (digit - old) * stride in two 24-bit halves and add
// it to the index. A write to a radix register starts a stride recompute,
// one multiply a cycle, during which no item is accepted.
// Errors (position of DIMS or more, index not below the total count, update
// digit not below the radix) give a result of zero with the error flag set.
// An output stall with a result held freezes the pipeline; the input stalls too.
`default_nettype none

module mixed_radix_index_digit_unit #(
    parameter int DIMS = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mridu_pkg::REG_W-1:0]     i_cfg_index,
    input  wire logic [mridu_pkg::RADIX_W-1:0]   i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_command,
    input  wire logic [mridu_pkg::POS_W-1:0]     i_position,
    input  wire logic [mridu_pkg::IDX_W-1:0]     i_flat_index,
    input  wire logic [mridu_pkg::RADIX_W-1:0]   i_digit_value,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [mridu_pkg::IDX_W-1:0]          o_result_value,
    output logic                                 o_error
);
    import mridu_pkg::*;

    localparam int CW = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int HW = IDX_W / 2;

    // Radix registers and derived strides
    logic [RADIX_W-1:0] r_radix [NREGS];
    logic [IDX_W-1:0]   r_stride [DIMS];
    logic [IDX_W-1:0]   r_total;

    // Stride recompute sequencer
    logic                      r_busy;
    logic [CW-1:0]             r_cnt;
    logic [IDX_W-1:0]          r_acc;
    logic [RADIX_W-1:0]        seq_radix;
    logic [IDX_W+RADIX_W-1:0]  seq_prod;

    // Pipeline
    logic  en;
    t_slot r_st [IDX_W+1];
    t_slot n_st [IDX_W+1];
    t_slot n_entry;

    logic                      r_t_valid, r_t_cmd, r_t_err;
    logic [IDX_W-1:0]          r_t_idx, r_t_s;
    logic [RADIX_W-1:0]        r_t_m;
    logic signed [RADIX_W:0]   r_t_delta;

    logic                      r_p_valid, r_p_cmd, r_p_err;
    logic [IDX_W-1:0]          r_p_idx;
    logic [RADIX_W-1:0]        r_p_m;
    logic signed [RADIX_W+HW:0] r_p_lo, r_p_hi;

    logic                      r_o_valid, r_o_err;
    logic [IDX_W-1:0]          r_o_res;
    logic signed [IDX_W-1:0]   ext_lo, ext_hi;
    logic [IDX_W-1:0]          n_res;

    // Hold everything while a finished result waits
    assign en      = !(r_o_valid && i_stall);
    assign o_stall = r_busy || !en;

    // ---------------- stride recompute ----------------
    always_comb begin
        seq_radix = RADIX_W'(1);
        for (int k = 0; k < NREGS; k++) begin
            if (32'(r_cnt) == k) begin
                seq_radix = r_radix[k];
            end
        end
        seq_prod = r_acc * seq_radix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NREGS; k++) begin
                r_radix[k] <= RADIX_W'(1);
            end
            for (int k = 0; k < DIMS; k++) begin
                r_stride[k] <= IDX_W'(1);
            end
            r_total <= IDX_W'(1);
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_acc   <= IDX_W'(1);
        end else if (i_cfg_we) begin
            r_radix[i_cfg_index] <= i_cfg_data;
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_acc  <= IDX_W'(1);
        end else if (r_busy) begin
            r_stride[r_cnt] <= r_acc;
            r_acc <= seq_prod[IDX_W-1:0];
            if (32'(r_cnt) == DIMS - 1) begin
                r_total <= seq_prod[IDX_W-1:0];
                r_busy  <= 1'b0;
            end else begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // ---------------- entry stage: range checks, pick stride and radix ----------------
    always_comb begin
        n_entry       = '0;
        n_entry.valid = i_valid && !r_busy;
        n_entry.cmd   = i_command;
        n_entry.idx   = i_flat_index;
        n_entry.dig   = i_digit_value;
        n_entry.s     = IDX_W'(1);
        n_entry.r     = RADIX_W'(1);
        for (int k = 0; k < DIMS; k++) begin
            if (32'(i_position) == k) begin
                n_entry.s = r_stride[k];
                if (k < NREGS) begin
                    n_entry.r = r_radix[k];
                end
            end
        end
        n_entry.err = (32'(i_position) >= DIMS) || (i_flat_index >= r_total)
                   || ((i_command == CMD_UPDATE) && (i_digit_value >= n_entry.r));
    end

    // ---------------- divider stages: one quotient bit each ----------------
    always_comb begin
        logic [IDX_W:0]   t;
        logic             qb;
        logic [RADIX_W:0] v;
        n_st[0] = n_entry;
        for (int j = 0; j < IDX_W; j++) begin
            n_st[j+1] = r_st[j];
            t  = {r_st[j].rem, r_st[j].idx[IDX_W-1-j]};
            qb = (t >= {1'b0, r_st[j].s});
            if (qb) begin
                t = t - {1'b0, r_st[j].s};
            end
            n_st[j+1].rem = t[IDX_W-1:0];
            // Fold quotient bit into quotient mod radix
            v = {r_st[j].m, qb};
            if (v >= {1'b0, r_st[j].r}) begin
                v = v - {1'b0, r_st[j].r};
            end
            n_st[j+1].m = v[RADIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= IDX_W; j++) begin
                r_st[j].valid <= 1'b0;
            end
        end else if (en) begin
            for (int j = 0; j <= IDX_W; j++) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    // ---------------- digit delta, split multiply, final add ----------------
    assign ext_lo = IDX_W'(r_p_lo);
    assign ext_hi = IDX_W'(r_p_hi);

    always_comb begin
        if (r_p_err) begin
            n_res = '0;
        end else if (r_p_cmd == CMD_DECODE) begin
            n_res = IDX_W'(r_p_m);
        end else begin
            n_res = r_p_idx + IDX_W'(ext_lo) + (IDX_W'(ext_hi) << HW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_t_valid <= r_st[IDX_W].valid;
            r_p_valid <= r_t_valid;
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_cmd   <= r_st[IDX_W].cmd;
            r_t_err   <= r_st[IDX_W].err;
            r_t_idx   <= r_st[IDX_W].idx;
            r_t_s     <= r_st[IDX_W].s;
            r_t_m     <= r_st[IDX_W].m;
            r_t_delta <= $signed({1'b0, r_st[IDX_W].dig}) - $signed({1'b0, r_st[IDX_W].m});

            r_p_cmd <= r_t_cmd;
            r_p_err <= r_t_err;
            r_p_idx <= r_t_idx;
            r_p_m   <= r_t_m;
            r_p_lo  <= r_t_delta * $signed({1'b0, r_t_s[HW-1:0]});
            r_p_hi  <= r_t_delta * $signed({1'b0, r_t_s[IDX_W-1:HW]});

            r_o_err <= r_p_err;
            r_o_res <= n_res;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_error        = r_o_err;
    assign o_result_value = r_o_res;

    // ---------------- checks ----------------
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_result_value == '0)
        else $error("error result carries nonzero value");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> o_stall)
        else $error("input open during stride recompute");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_busy)
        else $error("radix write did not start recompute");

endmodule

`default_nettype wire
